// ===== rtl/dlte_pkg.sv =====
// Shared types, command codes and fixed-point helpers of the dense layer training engine.
// Used by dlte_cell and the top level; depends on nothing else.
package dlte_pkg;

	localparam int IN_MAX    = 16;
	localparam int OUT_MAX   = 16;
	localparam int BATCH_MAX = 4;
	localparam int DATA_BITS = 16;
	localparam int FRAC      = 12;
	localparam int ACC_BITS  = 40;
	localparam int IDX_W     = 4;
	localparam int SMP_W     = 2;
	localparam int SIZE_W    = 5;
	localparam int BSZ_W     = 3;
	localparam int LR_W      = 16;
	localparam int GADDR_W   = IDX_W + SMP_W;

	typedef logic signed [DATA_BITS-1:0] data_t;
	typedef logic signed [ACC_BITS-1:0]  acc_t;
	typedef logic signed [ACC_BITS:0]    wide_t;
	typedef logic [IDX_W-1:0]            idx_t;
	typedef logic [SMP_W-1:0]            smp_t;

	localparam logic [2:0] CMD_LOAD_W = 3'd0;
	localparam logic [2:0] CMD_LOAD_B = 3'd1;
	localparam logic [2:0] CMD_FWD    = 3'd2;
	localparam logic [2:0] CMD_GRAD   = 3'd3;
	localparam logic [2:0] CMD_UPDATE = 3'd4;

	localparam logic [1:0] REG_IN_SIZE    = 2'd0;
	localparam logic [1:0] REG_OUT_SIZE   = 2'd1;
	localparam logic [1:0] REG_BATCH_SIZE = 2'd2;
	localparam logic [1:0] REG_LEARN_RATE = 2'd3;

	localparam logic KIND_Y  = 1'b0;
	localparam logic KIND_DX = 1'b1;

	typedef struct packed {
		logic [2:0] cmd;
		idx_t       row;
		idx_t       col;
		smp_t       sample;
		data_t      value;
		logic       final_req;
	} in_item_t;

	typedef struct packed {
		logic  kind;
		idx_t  index;
		smp_t  column;
		data_t result;
		logic  last;
	} out_item_t;

	// Store writes from an accepted item, seen by every cell.
	typedef struct packed {
		logic  wr_w;
		logic  wr_x;
		idx_t  row;
		idx_t  col;
		smp_t  smp;
		data_t val;
	} cell_wr_t;

	// One gradient element broadcast to all cells during the backward pass.
	typedef struct packed {
		logic  mac;
		logic  first_o;
		logic  first_s;
		logic  last_s;
		idx_t  o;
		smp_t  s;
		data_t g;
	} bwd_t;

	typedef struct packed {
		logic            en;
		idx_t            o;
		logic [LR_W-1:0] lr;
	} upd_t;

	typedef struct packed {
		logic shift;
		smp_t s;
	} drain_t;

	// Tag that travels down the chain next to a forward partial sum.
	typedef struct packed {
		logic valid;
		logic last;
		idx_t o;
		smp_t s;
	} fwd_tag_t;

	function automatic data_t sat_wide(input wide_t v);
		logic [ACC_BITS-DATA_BITS+1:0] hi;
		hi = v[ACC_BITS:DATA_BITS-1];
		if (hi == '0 || hi == '1) begin
			return v[DATA_BITS-1:0];
		end else if (v[ACC_BITS]) begin
			return {1'b1, {(DATA_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_BITS-1){1'b1}}};
		end
	endfunction

	// Round half up at the binary point of Q16.24 sums to Q4.12, then saturate.
	function automatic data_t round_acc(input acc_t a);
		wide_t t;
		wide_t sh;
		t  = wide_t'(a) + wide_t'(1 << (FRAC-1));
		sh = t >>> FRAC;
		return sat_wide(sh);
	endfunction

	// One descent step: w - round(lr * g / 2^16), saturated.
	function automatic data_t upd_value(input data_t w, input data_t g,
			input logic [LR_W-1:0] lr);
		logic signed [LR_W+DATA_BITS:0]   p;
		logic signed [LR_W+DATA_BITS+1:0] t;
		logic signed [DATA_BITS+1:0]      d;
		wide_t                            diff;
		p    = $signed({1'b0, lr}) * g;
		t    = (LR_W+DATA_BITS+2)'(p) + (LR_W+DATA_BITS+2)'(1 << (LR_W-1));
		d    = t[LR_W+DATA_BITS+1:LR_W];
		diff = wide_t'(w) - wide_t'(d);
		return sat_wide(diff);
	endfunction

endpackage

// ===== rtl/dlte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the gradient element store.
module dlte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/dlte_cell.sv =====
// One chain cell: holds one weight column, its input elements, its weight gradients
// and its input-gradient sums. Depends on dlte_pkg.
module dlte_cell import dlte_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  idx_t     cell_idx,
	input  logic     active,
	input  cell_wr_t wr,
	input  bwd_t     bwd,
	input  upd_t     upd,
	input  drain_t   drain,
	input  fwd_tag_t tag_in,
	input  acc_t     psum_in,
	output fwd_tag_t tag_out,
	output acc_t     psum_out,
	input  acc_t     dx_in,
	output acc_t     dx_out
);

	data_t    w_q  [OUT_MAX];
	data_t    dw_q [OUT_MAX];
	data_t    x_q  [BATCH_MAX];
	acc_t     dx_q [BATCH_MAX];
	acc_t     dwacc_q;
	fwd_tag_t tag_s1;
	acc_t     psum_s1;

	idx_t  w_addr;
	smp_t  x_addr;
	smp_t  dx_addr;
	data_t w_rd;
	data_t x_rd;
	acc_t  dx_rd;
	logic signed [2*DATA_BITS-1:0] wx_prod;
	logic signed [2*DATA_BITS-1:0] dx_prod;
	logic signed [2*DATA_BITS-1:0] dw_prod;
	acc_t  dw_sum;
	acc_t  fwd_add;

	always_comb begin
		if (upd.en) begin
			w_addr = upd.o;
		end else if (bwd.mac) begin
			w_addr = bwd.o;
		end else begin
			w_addr = tag_in.o;
		end
	end

	assign x_addr  = bwd.mac ? bwd.s : tag_in.s;
	assign dx_addr = drain.shift ? drain.s : bwd.s;
	assign w_rd    = w_q[w_addr];
	assign x_rd    = x_q[x_addr];
	assign dx_rd   = dx_q[dx_addr];

	assign wx_prod = w_rd * x_rd;
	assign dx_prod = w_rd * bwd.g;
	assign dw_prod = bwd.g * x_rd;
	assign dw_sum  = (bwd.first_s ? acc_t'(0) : dwacc_q) + acc_t'(dw_prod);
	assign fwd_add = (active && tag_in.valid) ? acc_t'(wx_prod) : acc_t'(0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		psum_s1 <= psum_in + fwd_add;
		if (wr.wr_w && wr.col == cell_idx) begin
			w_q[wr.row] <= wr.val;
		end else if (upd.en && active) begin
			w_q[upd.o] <= upd_value(w_rd, dw_q[upd.o], upd.lr);
		end
		if (wr.wr_x && wr.col == cell_idx) begin
			x_q[wr.smp] <= wr.val;
		end
		if (bwd.mac) begin
			dx_q[bwd.s] <= (bwd.first_o ? acc_t'(0) : dx_rd) + acc_t'(dx_prod);
			dwacc_q     <= dw_sum;
			if (bwd.last_s && active) begin
				dw_q[bwd.o] <= round_acc(dw_sum);
			end
		end else if (drain.shift) begin
			// Sums move one cell toward the head of the chain (cell 0).
			dx_q[drain.s] <= dx_in;
		end
	end

	assign tag_out  = tag_s1;
	assign psum_out = psum_s1;
	assign dx_out   = dx_rd;

endmodule

// ===== rtl/dense_layer_train_engine.sv =====
// Top level of the dense layer training engine: command sequencer, bias stores,
// gradient RAM and the row of IN_MAX chain cells. Depends on dlte_pkg, dlte_ram, dlte_cell.
//
//   port group                   direction  handshake
//   item   (in_item_t)           in         start high and busy low at a clock edge
//   res    (out_item_t)          out        res_valid high for one cycle, always taken
//   cfg_index, cfg_data          in         cfg_valid and cfg_ready high (ready always high)
//
// Loads and forward or gradient items without a final flag leave busy low; an update
// holds busy while it steps through every output.
// Forward final: every output of every sample is issued, then busy holds until the last
// sum leaves the chain. Backward final: every gradient element is read and broadcast,
// then the input-gradient sums are shifted out of the chain, one sample after another.
// Reset clears control state and sets the registers to their defaults; stores are
// undefined until written. Results cannot be stalled; busy holds off new items.
module dense_layer_train_engine import dlte_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  in_item_t            item,
	output logic                res_valid,
	output out_item_t           res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [LR_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD,
		ST_FWD_WAIT,
		ST_BWD,
		ST_BWD_WAIT,
		ST_DRAIN,
		ST_UPD
	} state_t;

	state_t            state_q;
	idx_t              o_q;
	smp_t              s_q;
	idx_t              k_q;
	logic [SIZE_W-1:0] in_size_q;
	logic [SIZE_W-1:0] out_size_q;
	logic [BSZ_W-1:0]  batch_size_q;
	logic [LR_W-1:0]   lr_q;
	logic              res_valid_q;
	out_item_t         res_q;

	data_t bias_q  [OUT_MAX];
	data_t bgrad_q [OUT_MAX];
	wide_t db_acc_q;
	bwd_t  bwd_s1;

	logic [SIZE_W-1:0] ni_eff;
	logic [SIZE_W-1:0] no_eff;
	logic [BSZ_W-1:0]  nb_eff;
	logic              accept;
	logic              o_last;
	logic              s_last;
	logic              k_emit;
	logic              k_last;
	logic [DATA_BITS-1:0] g_rdata;
	wide_t             db_sum;

	cell_wr_t cell_wr;
	bwd_t     bwd;
	upd_t     upd;
	drain_t   drain;

	fwd_tag_t tag_c  [IN_MAX+1];
	acc_t     psum_c [IN_MAX+1];
	acc_t     dx_c   [IN_MAX+1];

	always_comb begin
		if (in_size_q == '0) begin
			ni_eff = SIZE_W'(1);
		end else if (in_size_q > SIZE_W'(IN_MAX)) begin
			ni_eff = SIZE_W'(IN_MAX);
		end else begin
			ni_eff = in_size_q;
		end
		if (out_size_q == '0) begin
			no_eff = SIZE_W'(1);
		end else if (out_size_q > SIZE_W'(OUT_MAX)) begin
			no_eff = SIZE_W'(OUT_MAX);
		end else begin
			no_eff = out_size_q;
		end
		if (batch_size_q == '0) begin
			nb_eff = BSZ_W'(1);
		end else if (batch_size_q > BSZ_W'(BATCH_MAX)) begin
			nb_eff = BSZ_W'(BATCH_MAX);
		end else begin
			nb_eff = batch_size_q;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign o_last = ({1'b0, o_q} == no_eff - SIZE_W'(1));
	assign s_last = ({1'b0, s_q} == nb_eff - BSZ_W'(1));
	assign k_emit = ({1'b0, k_q} < ni_eff);
	assign k_last = ({1'b0, k_q} == ni_eff - SIZE_W'(1));

	always_comb begin
		cell_wr.wr_w = accept && item.cmd == CMD_LOAD_W;
		cell_wr.wr_x = accept && item.cmd == CMD_FWD;
		cell_wr.row  = item.row;
		cell_wr.col  = item.col;
		cell_wr.smp  = item.sample;
		cell_wr.val  = item.value;
	end

	always_comb begin
		bwd   = bwd_s1;
		bwd.g = data_t'(g_rdata);
	end

	assign upd.en      = (state_q == ST_UPD);
	assign upd.o       = o_q;
	assign upd.lr      = lr_q;
	assign drain.shift = (state_q == ST_DRAIN);
	assign drain.s     = s_q;

	// Forward items enter the chain head with the bias as the starting sum.
	assign tag_c[0].valid = (state_q == ST_FWD);
	assign tag_c[0].last  = o_last && s_last;
	assign tag_c[0].o     = o_q;
	assign tag_c[0].s     = s_q;
	assign psum_c[0]      = acc_t'(bias_q[o_q]) <<< FRAC;
	assign dx_c[IN_MAX]   = '0;

	for (genvar g = 0; g < IN_MAX; g++) begin : g_cell
		dlte_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.active   (SIZE_W'(g) < ni_eff),
			.wr       (cell_wr),
			.bwd      (bwd),
			.upd      (upd),
			.drain    (drain),
			.tag_in   (tag_c[g]),
			.psum_in  (psum_c[g]),
			.tag_out  (tag_c[g+1]),
			.psum_out (psum_c[g+1]),
			.dx_in    (dx_c[g+1]),
			.dx_out   (dx_c[g])
		);
	end

	dlte_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (OUT_MAX * BATCH_MAX)
	) u_grad_ram (
		.clk   (clk),
		.we    (accept && item.cmd == CMD_GRAD),
		.waddr ({item.row, item.sample}),
		.wdata (item.value),
		.raddr ({o_q, s_q}),
		.rdata (g_rdata)
	);

	assign db_sum = (bwd.first_s ? wide_t'(0) : db_acc_q) + wide_t'(bwd.g);

	always_ff @(posedge clk) begin
		if (accept && item.cmd == CMD_LOAD_B) begin
			bias_q[item.row] <= item.value;
		end else if (state_q == ST_UPD) begin
			bias_q[o_q] <= upd_value(bias_q[o_q], bgrad_q[o_q], lr_q);
		end
		if (bwd.mac) begin
			db_acc_q <= db_sum;
			if (bwd.last_s) begin
				bgrad_q[bwd.o] <= sat_wide(db_sum);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_size_q    <= SIZE_W'(16);
			out_size_q   <= SIZE_W'(16);
			batch_size_q <= BSZ_W'(1);
			lr_q         <= LR_W'(655);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IN_SIZE:    in_size_q    <= cfg_data[SIZE_W-1:0];
				REG_OUT_SIZE:   out_size_q   <= cfg_data[SIZE_W-1:0];
				REG_BATCH_SIZE: batch_size_q <= cfg_data[BSZ_W-1:0];
				REG_LEARN_RATE: lr_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			o_q         <= '0;
			s_q         <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			bwd_s1      <= '0;
		end else begin
			res_valid_q <= 1'b0;
			bwd_s1.mac  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					o_q <= '0;
					s_q <= '0;
					k_q <= '0;
					if (accept) begin
						case (item.cmd)
							CMD_FWD:    if (item.final_req) state_q <= ST_FWD;
							CMD_GRAD:   if (item.final_req) state_q <= ST_BWD;
							CMD_UPDATE: state_q <= ST_UPD;
							default: ;
						endcase
					end
				end
				ST_FWD: begin
					if (o_last) begin
						o_q <= '0;
						s_q <= s_q + SMP_W'(1);
						if (s_last) begin
							state_q <= ST_FWD_WAIT;
						end
					end else begin
						o_q <= o_q + IDX_W'(1);
					end
				end
				ST_FWD_WAIT: begin
					if (tag_c[IN_MAX].valid && tag_c[IN_MAX].last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BWD: begin
					// Gradient RAM read issued now; its data is broadcast next cycle.
					bwd_s1.mac     <= 1'b1;
					bwd_s1.first_o <= (o_q == '0);
					bwd_s1.first_s <= (s_q == '0);
					bwd_s1.last_s  <= s_last;
					bwd_s1.o       <= o_q;
					bwd_s1.s       <= s_q;
					if (s_last) begin
						s_q <= '0;
						o_q <= o_q + IDX_W'(1);
						if (o_last) begin
							state_q <= ST_BWD_WAIT;
						end
					end else begin
						s_q <= s_q + SMP_W'(1);
					end
				end
				ST_BWD_WAIT: begin
					s_q     <= '0;
					k_q     <= '0;
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (k_emit) begin
						res_valid_q   <= 1'b1;
						res_q.kind    <= KIND_DX;
						res_q.index   <= k_q;
						res_q.column  <= s_q;
						res_q.result  <= round_acc(dx_c[0]);
						res_q.last    <= k_last && s_last;
					end
					k_q <= k_q + IDX_W'(1);
					if (k_q == '1) begin
						s_q <= s_q + SMP_W'(1);
						if (s_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_UPD: begin
					o_q <= o_q + IDX_W'(1);
					if (o_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (tag_c[IN_MAX].valid) begin
				res_valid_q  <= 1'b1;
				res_q.kind   <= KIND_Y;
				res_q.index  <= tag_c[IN_MAX].o;
				res_q.column <= tag_c[IN_MAX].s;
				res_q.result <= round_acc(psum_c[IN_MAX]);
				res_q.last   <= tag_c[IN_MAX].last;
			end
		end
	end

endmodule
